// ===== hdl/fcw_pkg.sv =====
// fcw_pkg: shared types and constants of the cluster chain walker
// holds table geometry, field widths, opcodes, status codes and the
// command/status structs between the controller and the datapath

package fcw_pkg;

    localparam int FAT_DEPTH = 4096;
    localparam int MAX_CHAIN = 64;
    localparam int ADDR_W    = $clog2(FAT_DEPTH);

    localparam int CL_W  = 16;
    localparam int IDX_W = 12;
    localparam int LIM_W = 7;
    localparam int ST_W  = 2;

    localparam logic [CL_W-1:0] CHAIN_END = 16'hFFF8;
    // depth with one extra bit so that 65536 still fits
    localparam logic [CL_W:0]   DEPTH_X   = (CL_W+1)'(FAT_DEPTH);
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_CHAIN);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_WALK = 1'b1
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_NORMAL = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_LIMIT  = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_LOOK
    } t_state;

    typedef struct packed {
        logic    load_we;
        logic    walk_start;
        logic    advance;
        logic    emit;
        logic    emit_last;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        logic cur_empty;
        logic cur_beyond;
        logic next_end;
        logic at_limit;
        logic slot_free;
    } t_sts;

endpackage

// ===== hdl/fcw_ctrl.sv =====
// fcw_ctrl: walk sequencer of the cluster chain walker
// depends on fcw_pkg; drives commands to fcw_dpath and reads its status

module fcw_ctrl import fcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic i_opcode,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        s_axis_tready     = 1'b0;
        o_cmd.load_we     = 1'b0;
        o_cmd.walk_start  = 1'b0;
        o_cmd.advance     = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.emit_last   = 1'b0;
        o_cmd.emit_status = ST_NORMAL;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (t_opcode'(i_opcode) == OP_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // the table read for the cursor is issued this cycle
                if (i_sts.cur_empty || i_sts.cur_beyond) begin
                    if (i_sts.slot_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = i_sts.cur_empty ? ST_EMPTY : ST_BEYOND;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.next_end) begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_sts.at_limit) begin
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_LIMIT;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_stall_holds_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !i_sts.slot_free) |=> (r_state == S_LOOK))
        else $error("look state left while the output slot was full");

    a_final_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> s_axis_tready)
        else $error("walk did not return to idle after its final item");
`endif

endmodule

// ===== hdl/fcw_dpath.sv =====
// fcw_dpath: table memory, walk cursor, link counter, limit and output register
// depends on fcw_pkg; acts on commands from fcw_ctrl

module fcw_dpath import fcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [CL_W-1:0]  i_entry_value,
    input  logic [CL_W-1:0]  i_start_cluster,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [CL_W-1:0]  o_cluster,
    output logic             o_last,
    output logic [ST_W-1:0]  o_status
);

    logic [CL_W-1:0]  mem [FAT_DEPTH];
    logic [CL_W-1:0]  r_rdata;
    logic [CL_W-1:0]  r_cur;
    logic [LIM_W-1:0] r_count;
    logic [LIM_W-1:0] r_limit;
    logic [LIM_W-1:0] n_limit;
    logic             r_out_valid;
    logic [CL_W-1:0]  r_out_cluster;
    logic             r_out_last;
    logic [ST_W-1:0]  r_out_status;
    logic             load_in_range;

    assign load_in_range = ((CL_W+1)'(i_entry_index) < DEPTH_X);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && load_in_range) begin
            mem[ADDR_W'(i_entry_index)] <= i_entry_value;
        end
        r_rdata <= mem[r_cur[ADDR_W-1:0]];
    end

    // zero acts as one, above the maximum acts as the maximum
    always_comb begin
        n_limit = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            n_limit = LIM_W'(1);
        end else if (i_cfg_wdata > LIMIT_RESET) begin
            n_limit = LIMIT_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_count <= '0;
        end else if (i_cmd.walk_start) begin
            r_cur   <= i_start_cluster;
            r_count <= '0;
        end else if (i_cmd.advance) begin
            r_cur   <= r_rdata;
            r_count <= r_count + LIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_cluster <= (i_cmd.emit_status == ST_EMPTY) ? '0 : r_cur;
            r_out_last    <= i_cmd.emit_last;
            r_out_status  <= i_cmd.emit_status;
        end
    end

    assign o_sts.cur_empty  = (r_cur >= CHAIN_END);
    assign o_sts.cur_beyond = ({1'b0, r_cur} >= DEPTH_X);
    assign o_sts.next_end   = (r_rdata >= CHAIN_END);
    assign o_sts.at_limit   = (({1'b0, r_count} + (LIM_W+1)'(1)) >= {1'b0, r_limit});
    assign o_sts.slot_free  = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign o_cluster     = r_out_cluster;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;

`ifndef SYNTH
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.slot_free)
        else $error("item emitted into a full output register");

    a_empty_only_at_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.emit_status == ST_EMPTY) |-> (r_cur >= CHAIN_END))
        else $error("empty chain flagged for a live cursor");

    a_load_not_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_we |-> !(i_cmd.emit || i_cmd.advance))
        else $error("table write overlaps a walk step");

    a_limit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_limit != '0) && (r_limit <= LIMIT_RESET))
        else $error("chain limit register out of range");
`endif

endmodule

// ===== hdl/fat16_cluster_chain_walker.sv =====
// load items give no result; the next item is taken the cycle after
// a walk checks its start (empty or beyond table: one final item), then emits one item
// per link as output room allows; each link is one registered read of the table port
// a new item is taken once the final item of a walk sits in the output register
// reset is synchronous, active low: clears the sequencer, output valid, cursor and
// counter and sets the chain limit to 64; the table keeps its contents

module fat16_cluster_chain_walker import fcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_index[11:0], entry_value[27:12], start_cluster[43:28], zero fill
    input  logic [47:0]      s_axis_tdata,
    // opcode[0]
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // cluster[15:0]
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // status[1:0]
    output logic [1:0]       m_axis_tuser
);

    t_cmd cmd;
    t_sts sts;

    fcw_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_opcode      (s_axis_tuser[0]),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    fcw_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (s_axis_tdata[11:0]),
        .i_entry_value   (s_axis_tdata[27:12]),
        .i_start_cluster (s_axis_tdata[43:28]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .o_cluster       (m_axis_tdata),
        .o_last          (m_axis_tlast),
        .o_status        (m_axis_tuser)
    );

endmodule
